[rtl/core/orbavg_pkg.sv]
package orbavg_pkg;

    localparam int CNT_W        = 7;
    localparam int SMP_W        = 32;
    localparam int SUM_W        = SMP_W + CNT_W;
    localparam int MAX_SLOTS_DEF = 64;
    localparam int CAP_FLOOR    = 2;
    localparam int CAP_RESET    = 64;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_AVG   = 2'd3
    } t_op;

endpackage

[rtl/core/orbavg_if.sv]
interface orbavg_in_if;
    import orbavg_pkg::*;

    logic             valid;
    logic             ready;
    t_op              op;
    logic [SMP_W-1:0] sample;

    modport source (output valid, op, sample, input ready);
    modport sink   (input valid, op, sample, output ready);
endinterface

interface orbavg_out_if;
    import orbavg_pkg::*;

    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] value;
    logic             empty_res;
    logic [CNT_W-1:0] fill;

    modport source (output valid, value, empty_res, fill, input ready);
    modport sink   (input valid, value, empty_res, fill, output ready);
endinterface

[rtl/core/overwrite_ring_buffer_average.sv]
// Channel  Dir  Words carried                 Handshake
// -------  ---  ----------------------------  ------------------------------
// i_in     in   op, sample                    valid/ready
// o_out    out  value, empty_res, fill        valid/ready, output register
// i_cfg    in   capacity (i_cfg_wdata)        i_cfg_we, no wait, no read-back
//
// Push and pop go through accept, the slot memory read, then the result
// register load. Clear and average on an empty ring go from accept straight to
// the load. Any other average runs the radix-2 divider in between, which
// retires one quotient bit per cycle over the 39-bit running sum. Reset
// (i_rst_n low, synchronous) sets capacity to the smaller of 64 and MAX_SLOTS
// and empties the ring; the slot memory itself is not cleared. A new word is
// taken only when the previous one has finished; a finished result waits until
// the output register is free.
module overwrite_ring_buffer_average #(
    parameter int MAX_SLOTS = orbavg_pkg::MAX_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [orbavg_pkg::CNT_W-1:0]  i_cfg_wdata,
    orbavg_in_if.sink                     i_in,
    orbavg_out_if.source                  o_out
);
    import orbavg_pkg::*;

    localparam int AW      = $clog2(MAX_SLOTS);
    localparam int CMP_W   = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam logic [CNT_W-1:0] CAP_INIT =
        CNT_W'((MAX_SLOTS < CAP_RESET) ? MAX_SLOTS : CAP_RESET);
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MEM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cap;
    logic [AW-1:0]             r_wpos, n_wpos;
    logic [AW-1:0]             r_rpos, n_rpos;
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic                      r_out_valid, n_out_valid;

    t_op                       r_op, n_op;
    logic [SMP_W-1:0]          r_smp, n_smp;
    logic [SMP_W-1:0]          r_res, n_res;
    logic                      r_neg, n_neg;
    logic                      r_empty, n_empty;
    logic [SUM_W-1:0]          r_div_a, n_div_a;
    logic [CNT_W-1:0]          r_rem, n_rem;
    logic [STEP_W-1:0]         r_step, n_step;

    logic [SMP_W-1:0]          r_rdata;
    logic [SMP_W-1:0]          r_mem [MAX_SLOTS];

    logic                      in_acc;
    logic                      out_load;
    logic                      mem_we;
    logic                      cap_wr;
    logic [AW-1:0]             rd_addr;
    logic [SUM_W-1:0]          sum_mag;
    logic [CNT_W:0]            div_t;
    logic                      div_ge;

    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] pos,
                                            input logic [CNT_W-1:0] cap);
        logic [CMP_W-1:0] nxt;
        nxt = CMP_W'(pos) + CMP_W'(1);
        return (nxt >= CMP_W'(cap)) ? '0 : AW'(nxt);
    endfunction

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_load    = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign rd_addr     = (i_in.op == OP_PUSH) ? r_wpos : r_rpos;
    assign sum_mag     = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign div_t       = {r_rem, r_div_a[SUM_W-1]};
    assign div_ge      = (div_t >= {1'b0, r_count});
    assign cap_wr      = i_cfg_we && (i_cfg_wdata > CNT_W'(CAP_FLOOR));
    assign o_out.valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_wpos      = r_wpos;
        n_rpos      = r_rpos;
        n_count     = r_count;
        n_sum       = r_sum;
        n_op        = r_op;
        n_smp       = r_smp;
        n_res       = r_res;
        n_neg       = r_neg;
        n_empty     = r_empty;
        n_div_a     = r_div_a;
        n_rem       = r_rem;
        n_step      = r_step;
        mem_we      = 1'b0;
        n_out_valid = out_load ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = i_in.op;
                    n_smp   = i_in.sample;
                    n_res   = '0;
                    n_neg   = 1'b0;
                    n_empty = 1'b0;
                    unique case (i_in.op)
                        OP_PUSH, OP_POP: begin
                            n_state = S_MEM;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_sum   = '0;
                            n_rpos  = r_wpos;
                            n_state = S_EMIT;
                        end
                        OP_AVG: begin
                            if (r_count == '0) begin
                                n_empty = 1'b1;
                                n_state = S_EMIT;
                            end else begin
                                n_div_a = sum_mag;
                                n_neg   = r_sum[SUM_W-1];
                                n_rem   = '0;
                                n_step  = STEP_W'(SUM_W - 1);
                                n_state = S_DIV;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MEM: begin
                // read data of the addressed slot is valid now
                if (r_op == OP_PUSH) begin
                    mem_we = 1'b1;
                    if (r_count == r_cap) begin
                        // full: drop the oldest sample from the sum
                        n_sum  = r_sum - SUM_W'(signed'(r_rdata)) + SUM_W'(signed'(r_smp));
                        n_rpos = f_adv(r_rpos, r_cap);
                    end else begin
                        n_sum   = r_sum + SUM_W'(signed'(r_smp));
                        n_count = r_count + CNT_W'(1);
                    end
                    n_wpos = f_adv(r_wpos, r_cap);
                end else if (r_count == '0) begin
                    n_empty = 1'b1;
                end else begin
                    n_res   = r_rdata;
                    n_sum   = r_sum - SUM_W'(signed'(r_rdata));
                    n_rpos  = f_adv(r_rpos, r_cap);
                    n_count = r_count - CNT_W'(1);
                end
                n_state = S_EMIT;
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                n_rem   = div_ge ? CNT_W'(div_t - {1'b0, r_count}) : CNT_W'(div_t);
                n_div_a = {r_div_a[SUM_W-2:0], div_ge};
                if (r_step == '0) begin
                    n_res   = n_div_a[SMP_W-1:0];
                    n_state = S_EMIT;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_INIT;
            r_wpos      <= '0;
            r_rpos      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cap_wr) begin
                // accepted capacity empties the ring
                r_cap   <= (int'(i_cfg_wdata) > MAX_SLOTS) ? CAP_MAX : i_cfg_wdata;
                r_wpos  <= '0;
                r_rpos  <= '0;
                r_count <= '0;
                r_sum   <= '0;
            end else begin
                r_wpos  <= n_wpos;
                r_rpos  <= n_rpos;
                r_count <= n_count;
                r_sum   <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_smp   <= n_smp;
        r_res   <= n_res;
        r_neg   <= n_neg;
        r_empty <= n_empty;
        r_div_a <= n_div_a;
        r_rem   <= n_rem;
        r_step  <= n_step;
        if (out_load) begin
            o_out.value     <= r_neg ? SMP_W'(-r_res) : r_res;
            o_out.empty_res <= r_empty;
            o_out.fill      <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wpos] <= r_smp;
        end
    end

`ifndef SYNTHESIS
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("stored count exceeds capacity");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMP_W'(r_wpos) < CMP_W'(r_cap)) && (CMP_W'(r_rpos) < CMP_W'(r_cap)))
        else $error("ring position beyond capacity");

    a_pos_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_rpos) + int'(r_count) == int'(r_wpos)) ||
        (int'(r_rpos) + int'(r_count) == int'(r_wpos) + int'(r_cap)))
        else $error("read position, count and write position disagree");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_out.empty_res) |-> (o_out.value == '0))
        else $error("empty result carries a nonzero value");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count != '0))
        else $error("divide started with zero count");
`endif

endmodule
